// File: sv/sdro_pkg.sv
// Shared types and constants for the SCAN disk request ordering block.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package sdro_pkg;

	localparam int MaxRequests = 63;
	localparam int PosW        = 16;
	localparam int MoveW       = PosW + 1;
	localparam int FifoDepth   = 4;

	// Commands handed from the front end to the back end.
	typedef enum logic [1:0] {
		OP_HEAD,
		OP_LOW,
		OP_HIGH,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [PosW-1:0] pos;
		logic            last;
	} cmd_t;

	// Control and status of one sorting chain.
	typedef struct packed {
		logic            clr;
		logic            ins;
		logic            shift;
		logic [PosW-1:0] val;
	} chain_ctl_t;

	typedef struct packed {
		logic [PosW-1:0] top;
		logic            v0;
		logic            v1;
	} chain_stat_t;

endpackage

`default_nettype wire

// File: sv/sdro_fifo.sv
// Short command queue between the front end and the back end.
// Depends on sdro_pkg for the command type and depth.
`default_nettype none

module sdro_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire sdro_pkg::cmd_t din,
	input  wire logic          pop,
	output sdro_pkg::cmd_t     dout,
	output logic               empty,
	output logic               full
);

	localparam int PtrW = $clog2(sdro_pkg::FifoDepth);
	localparam int CntW = $clog2(sdro_pkg::FifoDepth + 1);

	sdro_pkg::cmd_t  mem_q [sdro_pkg::FifoDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CntW'(sdro_pkg::FifoDepth));
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PtrW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= PtrW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= CntW'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CntW'(count_q - 1'b1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("command queue written while full");

endmodule

`default_nettype wire

// File: sv/sdro_chain.sv
// Insertion sorting chain: a row of cells kept in ascending order, with the
// smallest value at cell 0. Values shift out from cell 0. Depends on sdro_pkg.
`default_nettype none

module sdro_chain #(
	parameter int Depth = sdro_pkg::MaxRequests + 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire sdro_pkg::chain_ctl_t ctl,
	output sdro_pkg::chain_stat_t     stat
);

	logic [sdro_pkg::PosW-1:0] cell_q  [Depth];
	logic [Depth-1:0]          valid_q;
	logic [Depth-1:0]          valid_eff;
	logic [Depth-1:0]          keep;

	// A clear in the same cycle as an insert leaves only the new value.
	assign valid_eff = ctl.clr ? '0 : valid_q;

	always_comb begin
		for (int i = 0; i < Depth; i++) begin
			keep[i] = valid_eff[i] && (cell_q[i] <= ctl.val);
		end
	end

	assign stat.top = cell_q[0];
	assign stat.v0  = valid_q[0];
	assign stat.v1  = (Depth > 1) ? valid_q[Depth > 1 ? 1 : 0] : 1'b0;

	always_ff @(posedge clk) begin
		for (int i = 0; i < Depth; i++) begin
			if (ctl.ins) begin
				if (!keep[i]) begin
					if (i == 0) begin
						cell_q[i] <= ctl.val;
					end else if (keep[i-1]) begin
						cell_q[i] <= ctl.val;
					end else begin
						cell_q[i] <= cell_q[i-1];
					end
				end
			end else if (ctl.shift && i < Depth - 1) begin
				cell_q[i] <= cell_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.ins) begin
			valid_q <= valid_eff | {valid_eff[Depth-2:0], 1'b1};
		end else if (ctl.shift) begin
			valid_q <= {1'b0, valid_q[Depth-1:1]};
		end else if (ctl.clr) begin
			valid_q <= '0;
		end
	end

endmodule

`default_nettype wire

// File: sv/sdro_front.sv
// Front end: accepts head and request items, tracks the open job and sorts
// each request into the low or high class. Depends on sdro_pkg.
`default_nettype none

module sdro_front #(
	parameter int MaxRequests = sdro_pkg::MaxRequests
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic                      kind,
	input  wire logic [sdro_pkg::PosW-1:0] position,
	input  wire logic                      last,
	input  wire logic                      full,
	output logic                           busy,
	output logic                           push,
	output sdro_pkg::cmd_t                 cmd
);

	localparam int Depth = MaxRequests + 1;
	localparam int CntW  = $clog2(Depth + 1);

	logic [CntW-1:0]           count_q;
	logic [sdro_pkg::PosW-1:0] head_q;
	logic                      accept;
	logic                      room;

	assign busy   = full;
	assign accept = start && !full;
	assign room   = (count_q < CntW'(Depth));

	always_comb begin
		cmd.pos  = position;
		cmd.last = 1'b0;
		cmd.op   = sdro_pkg::OP_HEAD;
		push     = 1'b0;
		if (accept) begin
			if (!kind) begin
				push = 1'b1;
			end else if (count_q != '0) begin
				cmd.last = last;
				if (room) begin
					push   = 1'b1;
					cmd.op = (position <= head_q) ? sdro_pkg::OP_LOW : sdro_pkg::OP_HIGH;
				end else if (last) begin
					push   = 1'b1;
					cmd.op = sdro_pkg::OP_EMIT;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q  <= '0;
		end else if (accept) begin
			if (!kind) begin
				head_q  <= position;
				count_q <= CntW'(1);
			end else if (count_q != '0) begin
				if (last) begin
					count_q <= '0;
				end else if (room) begin
					count_q <= CntW'(count_q + 1'b1);
				end
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("job holds more positions than the store");

endmodule

`default_nettype wire

// File: sv/sdro_back.sv
// Back end: takes commands from the queue, inserts positions into two sorting
// chains and emits the service order. Depends on sdro_pkg and sdro_chain.
`default_nettype none

module sdro_back #(
	parameter int MaxRequests = sdro_pkg::MaxRequests
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire sdro_pkg::cmd_t             cmd,
	input  wire logic                       empty,
	output logic                            pop,
	output logic                            strobe,
	output logic [sdro_pkg::PosW-1:0]       cylinder,
	output logic [sdro_pkg::MoveW-1:0]      total_movement,
	output logic                            final_res
);

	typedef enum logic {ST_IDLE, ST_EMIT} state_t;

	state_t                     state_q;
	logic                       strobe_q;
	logic                       final_q;
	logic [sdro_pkg::PosW-1:0]  cyl_q;
	logic [sdro_pkg::MoveW-1:0] move_q;
	logic [sdro_pkg::PosW-1:0]  head_q;
	logic [sdro_pkg::PosW-1:0]  max_q;

	sdro_pkg::chain_ctl_t  lo_ctl;
	sdro_pkg::chain_ctl_t  hi_ctl;
	sdro_pkg::chain_stat_t lo_stat;
	sdro_pkg::chain_stat_t hi_stat;

	logic take;
	logic emit_lo;
	logic final_c;

	assign take    = (state_q == ST_IDLE) && !empty;
	assign pop     = take;
	assign emit_lo = (state_q == ST_EMIT) && lo_stat.v0;
	assign final_c = emit_lo ? (!lo_stat.v1 && !hi_stat.v0) : !hi_stat.v1;

	// The low chain holds inverted values so that its ascending order is the
	// descending order of the positions at or below the head.
	always_comb begin
		lo_ctl.clr   = take && (cmd.op == sdro_pkg::OP_HEAD);
		lo_ctl.ins   = take && (cmd.op == sdro_pkg::OP_HEAD || cmd.op == sdro_pkg::OP_LOW);
		lo_ctl.shift = emit_lo;
		lo_ctl.val   = ~cmd.pos;
		hi_ctl.clr   = take && (cmd.op == sdro_pkg::OP_HEAD);
		hi_ctl.ins   = take && (cmd.op == sdro_pkg::OP_HIGH);
		hi_ctl.shift = (state_q == ST_EMIT) && !lo_stat.v0;
		hi_ctl.val   = cmd.pos;
	end

	sdro_chain #(.Depth(MaxRequests + 1)) u_lo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lo_ctl),
		.stat   (lo_stat)
	);

	sdro_chain #(.Depth(MaxRequests + 1)) u_hi (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (hi_ctl),
		.stat   (hi_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			final_q  <= 1'b0;
			cyl_q    <= '0;
			move_q   <= '0;
			head_q   <= '0;
			max_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					strobe_q <= 1'b0;
					final_q  <= 1'b0;
					if (take) begin
						if (cmd.op == sdro_pkg::OP_HEAD) begin
							head_q <= cmd.pos;
							max_q  <= cmd.pos;
						end else if ((cmd.op inside {sdro_pkg::OP_LOW, sdro_pkg::OP_HIGH})
							&& cmd.pos > max_q) begin
							max_q <= cmd.pos;
						end
						if (cmd.last) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					cyl_q    <= emit_lo ? ~lo_stat.top : hi_stat.top;
					final_q  <= final_c;
					move_q   <= final_c ? sdro_pkg::MoveW'({1'b0, head_q} + {1'b0, max_q}) : '0;
					if (final_c) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe         = strobe_q;
	assign cylinder       = cyl_q;
	assign total_movement = move_q;
	assign final_res      = final_q;

	a_final_marked: assert property (@(posedge clk) disable iff (!arst_n)
		final_q |-> strobe_q)
		else $error("final mark without a result");

	a_gap_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && final_q) |=> !strobe_q)
		else $error("result directly after the final result of a job");

	a_emit_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (lo_stat.v0 || hi_stat.v0))
		else $error("emission with both chains empty");

endmodule

`default_nettype wire

// File: sv/scan_disk_request_order_top.sv
// Top level of the SCAN disk request ordering block.
// Depends on sdro_pkg, sdro_front, sdro_fifo and sdro_back.
//
// A job opens with a head item (kind 0) and continues with request items
// (kind 1), the last of which carries last. Items are taken whenever start is
// high and busy is low; busy rises only when the four-word command queue
// between the front end and the back end is full. The back end, while not
// emitting, inserts one queued position per cycle into one of two sorting
// chains (positions at or below the head, and positions above it). When the
// last request has been inserted, the job's results follow at one word per
// cycle: the head and every position at or below it in descending order, then
// the positions above the head in ascending order. Each result is shown for
// exactly one cycle with strobe high and cannot be held off by the receiver;
// total_movement is the head plus the largest position on the result that
// has final_res set, and zero on every other result. A new head while a job
// is open restarts the job, a request with no open job is dropped, and
// requests beyond MAX_REQUESTS are dropped while their last mark still closes
// the job.
`default_nettype none

module scan_disk_request_order_top #(
	parameter int MAX_REQUESTS = sdro_pkg::MaxRequests
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic                       kind,
	input  wire logic [sdro_pkg::PosW-1:0]  position,
	input  wire logic                       last,
	output logic                            strobe,
	output logic [sdro_pkg::PosW-1:0]       cylinder,
	output logic [sdro_pkg::MoveW-1:0]      total_movement,
	output logic                            final_res
);

	sdro_pkg::cmd_t push_cmd;
	sdro_pkg::cmd_t head_cmd;
	logic           push;
	logic           pop;
	logic           empty;
	logic           full;

	// Front end: job tracking and low/high classification against the head.
	sdro_front #(.MaxRequests(MAX_REQUESTS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.kind     (kind),
		.position (position),
		.last     (last),
		.full     (full),
		.busy     (busy),
		.push     (push),
		.cmd      (push_cmd)
	);

	// Queue that lets loading continue while the back end emits a job.
	sdro_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_cmd),
		.pop    (pop),
		.dout   (head_cmd),
		.empty  (empty),
		.full   (full)
	);

	// Back end: sorting chains and the emission sequencer.
	sdro_back #(.MaxRequests(MAX_REQUESTS)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (head_cmd),
		.empty          (empty),
		.pop            (pop),
		.strobe         (strobe),
		.cylinder       (cylinder),
		.total_movement (total_movement),
		.final_res      (final_res)
	);

endmodule

`default_nettype wire
